// ===== design/lztd_pkg.sv =====
// ----------------------------------------------------------------------------
// lztd_pkg: shared definitions for the LZ77 token decompressor
// Sizes, status and command codes, and the command word passed from the
// parser to the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lztd_pkg;

  // history size and lanes per result
  localparam int FRAME_MAX = 1024;
  localparam int LANES     = 4;
  localparam int CHUNK     = (LANES < 4) ? LANES : 4;
  localparam int CHUNK_W   = $clog2(CHUNK);

  // history addressing: one bank per lane, byte interleaved
  localparam int AW   = $clog2(FRAME_MAX);
  localparam int CW   = $clog2(FRAME_MAX + 1);
  localparam int RW   = AW - CHUNK_W;
  localparam int ROWS = 2 ** RW;

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 11;
  localparam int FLEN_W  = 11;
  localparam int CNT_W   = 3;
  localparam int OFF_W   = 16;
  localparam int CMP_W   = OFF_W + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [BYTE_W-1:0]  TOKEN_COPY  = 8'h80;
  localparam logic [6:0]         LEN_MASK    = 7'h7F;

  // command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_DONE   = 3'd1,
    ST_TRUNC  = 3'd2,
    ST_OVER   = 3'd3,
    ST_ZERO   = 3'd4,
    ST_OFFSET = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_LIT,
    OP_COPY,
    OP_NOTE
  } op_e;

  // one command for the copy engine
  //   data : literal byte or copy length
  //   trail: after the data word, send a byte-less word carrying st
  //   fin  : frame ends with this command
  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic [CW-1:0]     off;
    status_e           st;
    logic              trail;
    logic              fin;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/lztd_if.sv =====
// ----------------------------------------------------------------------------
// lztd_if: channel interfaces of the LZ77 token decompressor
// Compressed byte input, decompressed word output and the limit write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface lztd_in_if;
  logic                       valid;
  logic                       ready;
  logic [lztd_pkg::BYTE_W-1:0] in_byte;
  logic                       frame_last;

  modport source (output valid, output in_byte, output frame_last, input ready);
  modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

interface lztd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lztd_pkg::BYTE_W-1:0] byte_lane0;
  logic [lztd_pkg::BYTE_W-1:0] byte_lane1;
  logic [lztd_pkg::BYTE_W-1:0] byte_lane2;
  logic [lztd_pkg::BYTE_W-1:0] byte_lane3;
  logic [lztd_pkg::CNT_W-1:0]  byte_count;
  logic                        run_last;
  logic [2:0]                  status;
  logic [lztd_pkg::FLEN_W-1:0] frame_length;

  modport source (output valid, output byte_lane0, output byte_lane1,
                  output byte_lane2, output byte_lane3, output byte_count,
                  output run_last, output status, output frame_length,
                  input ready);
  modport sink   (input valid, input byte_lane0, input byte_lane1,
                  input byte_lane2, input byte_lane3, input byte_count,
                  input run_last, input status, input frame_length,
                  output ready);
endinterface

interface lztd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lztd_pkg::LIMIT_W-1:0] output_limit;

  modport source (output valid, output output_limit, input ready);
  modport sink   (input valid, input output_limit, output ready);
endinterface

`default_nettype wire

// ===== design/lztd_front.sv =====
// ----------------------------------------------------------------------------
// lztd_front: token parser
// Takes one compressed byte per cycle unless the queue is full, tracks token
// phase and frame byte count, checks limits and offsets, and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lztd_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lztd_in_if.sink                           in_i,
  input  wire logic [lztd_pkg::LIMIT_W-1:0] limit_i,
  input  wire logic                         full_i,
  output      logic                         push_o,
  output      lztd_pkg::cmd_t               cmd_o
);
  import lztd_pkg::*;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_OFFLO,
    PH_LENGTH,
    PH_LITERAL
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [6:0]       rem_q, rem_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [CW-1:0]    prod_q, prod_d;
  logic             err_q, err_d;

  logic             accept;
  logic [CMP_W-1:0] lim, lim_cfg, prod_ext, lit_sum, cpy_sum;
  logic [6:0]       lit_len;
  logic [6:0]       rem_dec;
  logic             last;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign last       = in_i.frame_last;

  // limit in force and running sums
  always_comb begin
    lim_cfg  = CMP_W'(limit_i);
    lim      = (lim_cfg < CMP_W'(FRAME_MAX)) ? lim_cfg : CMP_W'(FRAME_MAX);
    prod_ext = CMP_W'(prod_q);
    lit_len  = in_i.in_byte[6:0] & LEN_MASK;
    lit_sum  = prod_ext + CMP_W'(lit_len);
    cpy_sum  = prod_ext + CMP_W'(in_i.in_byte);
    rem_dec  = rem_q - 7'd1;
  end

  // parse one byte
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    off_d   = off_q;
    prod_d  = prod_q;
    err_d   = err_q;
    push_o  = 1'b0;
    cmd_o   = '{op: OP_NOTE, data: in_i.in_byte, off: '0, st: ST_DATA,
                trail: 1'b0, fin: last};

    if (accept) begin
      if (!err_q) begin
        unique case (phase_q)
          PH_TOKEN: begin
            if (in_i.in_byte < TOKEN_COPY) begin
              if (lit_sum > lim) begin
                push_o    = 1'b1;
                cmd_o.st  = ST_OVER;
                cmd_o.fin = 1'b1;
                err_d     = 1'b1;
              end else if (lit_len != 7'd0) begin
                rem_d   = lit_len;
                phase_d = PH_LITERAL;
                if (last) begin
                  push_o   = 1'b1;
                  cmd_o.st = ST_TRUNC;
                end
              end else if (last) begin
                push_o   = 1'b1;
                cmd_o.st = ST_DONE;
              end
            end else begin
              off_d   = {1'b0, in_i.in_byte[6:0], 8'h00};
              phase_d = PH_OFFLO;
              if (last) begin
                push_o   = 1'b1;
                cmd_o.st = ST_TRUNC;
              end
            end
          end
          PH_OFFLO: begin
            off_d   = {off_q[OFF_W-1:BYTE_W], in_i.in_byte} + OFF_W'(1);
            phase_d = PH_LENGTH;
            if (last) begin
              push_o   = 1'b1;
              cmd_o.st = ST_TRUNC;
            end
          end
          PH_LENGTH: begin
            phase_d = PH_TOKEN;
            push_o  = 1'b1;
            priority if (in_i.in_byte == '0) begin
              cmd_o.st  = ST_ZERO;
              cmd_o.fin = 1'b1;
              err_d     = 1'b1;
            end else if (CMP_W'(off_q) > prod_ext) begin
              cmd_o.st  = ST_OFFSET;
              cmd_o.fin = 1'b1;
              err_d     = 1'b1;
            end else if (cpy_sum > lim) begin
              cmd_o.st  = ST_OVER;
              cmd_o.fin = 1'b1;
              err_d     = 1'b1;
            end else begin
              cmd_o.op  = OP_COPY;
              cmd_o.off = CW'(off_q);
              cmd_o.st  = last ? ST_DONE : ST_DATA;
              prod_d    = CW'(cpy_sum);
            end
          end
          PH_LITERAL: begin
            push_o   = 1'b1;
            cmd_o.op = OP_LIT;
            prod_d   = prod_q + CW'(1);
            rem_d    = rem_dec;
            if (rem_dec == 7'd0) begin
              phase_d  = PH_TOKEN;
              cmd_o.st = last ? ST_DONE : ST_DATA;
            end else if (last) begin
              cmd_o.st    = ST_TRUNC;
              cmd_o.trail = 1'b1;
            end
          end
          default: begin
            phase_d = PH_TOKEN;
          end
        endcase
      end

      // every frame end returns the parser to its start
      if (last) begin
        phase_d = PH_TOKEN;
        rem_d   = '0;
        off_d   = '0;
        prod_d  = '0;
        err_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN;
      rem_q   <= '0;
      off_q   <= '0;
      prod_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      prod_q  <= prod_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/lztd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lztd_cmd_fifo: command queue
// Short first-in first-out queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lztd_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lztd_pkg::cmd_t cmd_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           empty_o,
  output      lztd_pkg::cmd_t cmd_o
);
  import lztd_pkg::*;

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/lztd_back.sv =====
// ----------------------------------------------------------------------------
// lztd_back: copy engine
// Executes queued commands: passes literals, copies back references from
// the banked frame history up to four bytes per word, and sends status.
// ----------------------------------------------------------------------------
`default_nettype none

module lztd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire lztd_pkg::cmd_t cmd_i,
  output      logic           pop_o,
  lztd_out_if.source          out_o
);
  import lztd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIT,
    S_RD,
    S_COPY,
    S_NOTE
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [BYTE_W-1:0]   len_q;
  logic [CW-1:0]       prod_q, prod_d;
  logic [BYTE_W-1:0]   tail_q [CHUNK];
  logic [BYTE_W-1:0]   tail_d [CHUNK];

  // history banks, one byte lane each
  logic [BYTE_W-1:0]   ram_q   [CHUNK][ROWS];
  logic [BYTE_W-1:0]   rdata_q [CHUNK];
  logic [CHUNK_W-1:0]  s_lo_q;
  logic [CW-1:0]       s_rd;
  logic [RW-1:0]       raddr [CHUNK];
  logic [RW-1:0]       waddr [CHUNK];
  logic [BYTE_W-1:0]   wdata [CHUNK];
  logic                we    [CHUNK];

  // output register
  logic                out_valid_q;
  logic [BYTE_W-1:0]   lane_q [CHUNK];
  logic [CNT_W-1:0]    cnt_q;
  logic                run_last_q;
  status_e             st_q;
  logic [FLEN_W-1:0]   flen_q;

  logic [BYTE_W-1:0]   lanes [CHUNK];
  logic [CNT_W-1:0]    cnt;
  logic                emit, data_word, last_chunk, fire, word_last, done_cmd;
  status_e             emit_st;
  logic [CW-1:0]       src_gap;
  logic [CHUNK_W-1:0]  bank_sel;

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign fire  = emit && (!out_valid_q || out_o.ready);

  // word contents for the current state
  always_comb begin
    last_chunk = (len_q <= BYTE_W'(CHUNK));
    cnt        = '0;
    emit       = 1'b0;
    data_word  = 1'b0;
    word_last  = 1'b1;
    emit_st    = cmd_q.st;
    done_cmd   = 1'b0;
    src_gap    = '0;
    bank_sel   = '0;
    for (int i = 0; i < CHUNK; i++) begin
      lanes[i] = '0;
    end

    unique case (state_q)
      S_LIT: begin
        emit      = 1'b1;
        data_word = 1'b1;
        cnt       = CNT_W'(1);
        lanes[0]  = cmd_q.data;
        word_last = !cmd_q.trail;
        emit_st   = cmd_q.trail ? ST_DATA : cmd_q.st;
        done_cmd  = !cmd_q.trail;
      end
      S_COPY: begin
        emit      = 1'b1;
        data_word = 1'b1;
        cnt       = last_chunk ? CNT_W'(len_q) : CNT_W'(CHUNK);
        word_last = last_chunk;
        emit_st   = last_chunk ? cmd_q.st : ST_DATA;
        done_cmd  = last_chunk;
        // source byte: this word, the last bytes written, or the history
        for (int i = 0; i < CHUNK; i++) begin
          bank_sel = s_lo_q + CHUNK_W'(i);
          lanes[i] = rdata_q[bank_sel];
          if (cmd_q.off > CW'(i)) begin
            src_gap = cmd_q.off - CW'(i);
            if (src_gap <= CW'(CHUNK)) begin
              lanes[i] = tail_q[CHUNK_W'(src_gap - CW'(1))];
            end
          end else begin
            for (int j = 0; j < i; j++) begin
              if (CW'(j) + cmd_q.off == CW'(i)) begin
                lanes[i] = lanes[j];
              end
            end
          end
        end
      end
      S_NOTE: begin
        emit     = 1'b1;
        done_cmd = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // byte count, last bytes written, history read and write ports
  always_comb begin
    prod_d = prod_q;
    if (fire && data_word) begin
      prod_d = prod_q + CW'(cnt);
    end
    if (fire && done_cmd && cmd_q.fin) begin
      prod_d = '0;
    end

    for (int j = 0; j < CHUNK; j++) begin
      tail_d[j] = tail_q[j];
      if (fire && data_word) begin
        if (CNT_W'(j) < cnt) begin
          tail_d[j] = lanes[CHUNK_W'(int'(cnt) - 1 - j)];
        end else begin
          tail_d[j] = tail_q[CHUNK_W'(j - int'(cnt))];
        end
      end
    end

    // next word reads from prod_d - off, rotated into lanes
    s_rd = prod_d - cmd_q.off;
    for (int b = 0; b < CHUNK; b++) begin
      logic [AW-1:0]      ra, wa;
      logic [CHUNK_W-1:0] wi;
      ra       = s_rd[AW-1:0]
               + AW'(CHUNK_W'(CHUNK_W'(b) - s_rd[CHUNK_W-1:0]));
      raddr[b] = ra[AW-1:CHUNK_W];
      wi       = CHUNK_W'(b) - prod_q[CHUNK_W-1:0];
      wa       = prod_q[AW-1:0] + AW'(wi);
      waddr[b] = wa[AW-1:CHUNK_W];
      wdata[b] = lanes[wi];
      we[b]    = fire && data_word && (CNT_W'(wi) < cnt);
    end
  end

  // history banks
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < CHUNK; b++) begin
      if (we[b]) begin
        ram_q[b][waddr[b]] <= wdata[b];
      end
      rdata_q[b] <= ram_q[b][raddr[b]];
    end
    s_lo_q <= s_rd[CHUNK_W-1:0];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (fire) begin
      for (int i = 0; i < CHUNK; i++) begin
        lane_q[i] <= (CNT_W'(i) < cnt) ? lanes[i] : '0;
      end
      cnt_q      <= cnt;
      run_last_q <= word_last;
      st_q       <= emit_st;
      flen_q     <= FLEN_W'(prod_q + CW'(cnt));
    end
    tail_q <= tail_d;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= prod_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            len_q <= cmd_i.data;
            unique case (cmd_i.op)
              OP_LIT:  state_q <= S_LIT;
              OP_COPY: state_q <= S_RD;
              default: state_q <= S_NOTE;
            endcase
          end
        end
        S_LIT: begin
          if (fire) begin
            state_q <= cmd_q.trail ? S_NOTE : S_IDLE;
          end
        end
        S_RD: begin
          state_q <= S_COPY;
        end
        S_COPY: begin
          if (fire) begin
            len_q <= len_q - BYTE_W'(cnt);
            if (last_chunk) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_NOTE: begin
          if (fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.byte_lane0   = lane_q[0];
  assign out_o.byte_lane1   = lane_q[1];
  assign out_o.byte_lane2   = lane_q[2];
  assign out_o.byte_lane3   = lane_q[3];
  assign out_o.byte_count   = cnt_q;
  assign out_o.run_last     = run_last_q;
  assign out_o.status       = st_q;
  assign out_o.frame_length = flen_q;

endmodule

`default_nettype wire

// ===== design/lz77_token_decompressor_top.sv =====
// Literal byte: queued, sent as one word from S_LIT; the next pop waits for S_IDLE.
// Back reference: a history read in S_RD, then words of up to four bytes from S_COPY.
// Token and offset bytes go to the parser, which runs ahead through a 4-entry queue.
// Reset (async, active low) clears parser, queue, engine and output valid;
// the history memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// lz77_token_decompressor_top: LZ77 token decompressor
// Parser front end, command queue and copy engine, plus the limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_token_decompressor_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lztd_in_if.sink   in_i,
  lztd_cfg_if.sink  cfg_i,
  lztd_out_if.source out_o
);
  import lztd_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               push, full, pop, empty;
  cmd_t               cmd_in, cmd_out;

  // output limit register, writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.output_limit;
    end
  end

  lztd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .limit_i (limit_q),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (cmd_in)
  );

  lztd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  lztd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== design/lztd_checker.sv =====
// ----------------------------------------------------------------------------
// lztd_checker: port-level checks for the LZ77 token decompressor
// Word format rules seen on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lztd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  lane3,
  input wire logic [2:0]  byte_count,
  input wire logic        run_last,
  input wire logic [2:0]  status,
  input wire logic [10:0] frame_length
);
  import lztd_pkg::*;

  // error and truncation words carry no bytes and end the run
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_DATA && status != ST_DONE
      |-> byte_count == '0 && run_last)
    else $error("error word with bytes or without run_last");

  // a data word always carries at least one byte, at most four
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ST_DATA |-> byte_count != '0 && byte_count <= 3'd4)
    else $error("data word with bad byte count");

  // unused top lane reads as zero
  a_lane_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && byte_count < 3'd4 |-> lane3 == '0)
    else $error("lane above byte count not zero");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(byte_count)
      && $stable(status) && $stable(frame_length))
    else $error("output word changed while stalled");

endmodule

bind lz77_token_decompressor_top lztd_checker u_lztd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .lane3        (out_o.byte_lane3),
  .byte_count   (out_o.byte_count),
  .run_last     (out_o.run_last),
  .status       (out_o.status),
  .frame_length (out_o.frame_length)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the LZ77 token decompressor
// Feeds compressed frames (directed corner cases, then random well-formed and
// broken frames) under several output limits, with random idling on both
// sides. A frame decoder in the checker class predicts every output word;
// each accepted word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

import lztd_pkg::*;

typedef enum logic [1:0] {
  PH_TOKEN,
  PH_OFF_LO,
  PH_LENGTH,
  PH_LITERAL
} parse_phase_e;

// one output word, lanes[0] is byte_lane0
typedef struct packed {
  logic [3:0][BYTE_W-1:0] lanes;
  logic [CNT_W-1:0]       count;
  logic                   run_last;
  status_e                status;
  logic [FLEN_W-1:0]      flen;
} lz_word_t;

// Frame decoder and store of predicted output words
class lz_frame_checker;
  logic [BYTE_W-1:0]  history [FRAME_MAX];
  int unsigned        produced;
  int unsigned        lit_left;
  int unsigned        back_off;
  parse_phase_e       phase;
  bit                 err_seen;
  logic [LIMIT_W-1:0] limit_reg;
  lz_word_t           expected_words[$];
  int unsigned        mismatches;

  function new();
    limit_reg  = LIMIT_RESET;
    mismatches = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    produced = 0;
    phase    = PH_TOKEN;
    lit_left = 0;
    back_off = 0;
    err_seen = 1'b0;
  endfunction

  function void set_limit(logic [LIMIT_W-1:0] v);
    limit_reg = v;
  endfunction

  function int unsigned limit_now();
    return (limit_reg < FRAME_MAX) ? int'(limit_reg) : FRAME_MAX;
  endfunction

  function void queue_word(logic [3:0][BYTE_W-1:0] lanes, int unsigned cnt, status_e st);
    lz_word_t w;
    w.lanes    = lanes;
    w.count    = CNT_W'(cnt);
    w.run_last = 1'b0;
    w.status   = st;
    w.flen     = FLEN_W'(produced);
    expected_words.push_back(w);
  endfunction

  function void keep_byte(logic [BYTE_W-1:0] v);
    if (produced < FRAME_MAX) begin
      history[produced] = v;
      produced++;
    end
  endfunction

  // Decode one accepted compressed byte and predict the words it causes
  function void note_byte(logic [BYTE_W-1:0] b, bit is_last);
    int unsigned             base;
    int unsigned             len;
    int unsigned             cnt;
    int unsigned             src;
    bit                      err_now;
    logic [3:0][BYTE_W-1:0] lanes;
    lz_word_t                w;
    base    = expected_words.size();
    err_now = 1'b0;
    lanes   = '0;
    if (!err_seen) begin
      case (phase)
        PH_TOKEN: begin
          if (b < TOKEN_COPY) begin
            len = b[6:0];
            if (produced + len > limit_now()) begin
              queue_word('0, 0, ST_OVER);
              err_now = 1'b1;
            end else if (len != 0) begin
              lit_left = len;
              phase    = PH_LITERAL;
            end
          end else begin
            back_off = {b[6:0], 8'h00};
            phase    = PH_OFF_LO;
          end
        end
        PH_OFF_LO: begin
          back_off = (back_off | b) + 1;
          phase    = PH_LENGTH;
        end
        PH_LENGTH: begin
          len   = b;
          phase = PH_TOKEN;
          // zero length beats bad offset, bad offset beats overflow
          if (len == 0) begin
            queue_word('0, 0, ST_ZERO);
            err_now = 1'b1;
          end else if (back_off > produced) begin
            queue_word('0, 0, ST_OFFSET);
            err_now = 1'b1;
          end else if (produced + len > limit_now()) begin
            queue_word('0, 0, ST_OVER);
            err_now = 1'b1;
          end else begin
            // copy may overlap the bytes being written
            while (len != 0) begin
              cnt   = (len < CHUNK) ? len : CHUNK;
              lanes = '0;
              for (int i = 0; i < cnt; i++) begin
                src      = produced - back_off;
                lanes[i] = history[src];
                keep_byte(history[src]);
              end
              queue_word(lanes, cnt, ST_DATA);
              len -= cnt;
            end
          end
        end
        default: begin
          lanes[0] = b;
          keep_byte(b);
          queue_word(lanes, 1, ST_DATA);
          lit_left--;
          if (lit_left == 0) phase = PH_TOKEN;
        end
      endcase

      if (err_now) begin
        err_seen = 1'b1;
      end else if (is_last) begin
        if (phase != PH_TOKEN) begin
          queue_word('0, 0, ST_TRUNC);
        end else if (expected_words.size() > base) begin
          w        = expected_words.pop_back();
          w.status = ST_DONE;
          expected_words.push_back(w);
        end else begin
          queue_word('0, 0, ST_DONE);
        end
      end
    end

    if (expected_words.size() > base) begin
      w          = expected_words.pop_back();
      w.run_last = 1'b1;
      expected_words.push_back(w);
    end
    if (is_last) clear_frame();
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare one accepted output word with the oldest prediction
  function void check_word(lz_word_t got);
    lz_word_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected output word, expected none, actual count %0d status %0d len %0d",
               $time, got.count, got.status, got.flen);
      return;
    end
    want = expected_words.pop_front();
    for (int i = 0; i < 4; i++)
      compare_field($sformatf("byte_lane%0d", i), want.lanes[i], got.lanes[i]);
    compare_field("byte_count", want.count, got.count);
    compare_field("run_last", want.run_last, got.run_last);
    compare_field("status", want.status, got.status);
    compare_field("frame_length", want.flen, got.flen);
  endfunction

  function void finish_check();
    if (expected_words.size() != 0) begin
      $display("%0t: output words missing, expected %0d more, actual 0",
               $time, expected_words.size());
      mismatches += expected_words.size();
    end
  endfunction
endclass

module tb;

  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  bit   no_idle = 1'b0;

  lztd_in_if  in_if();
  lztd_cfg_if cfg_if();
  lztd_out_if out_if();

  lz77_token_decompressor_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  lz_frame_checker   sb = new();
  logic [BYTE_W-1:0] frame_bytes[$];
  lz_word_t          got_word;
  bit                fired;
  int unsigned       stall_cycles = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random backpressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      fired = 1'b0;
      if (out_if.valid && out_if.ready) begin
        got_word.lanes    = {out_if.byte_lane3, out_if.byte_lane2,
                             out_if.byte_lane1, out_if.byte_lane0};
        got_word.count    = out_if.byte_count;
        got_word.run_last = out_if.run_last;
        got_word.status   = status_e'(out_if.status);
        got_word.flen     = out_if.frame_length;
        sb.check_word(got_word);
        fired = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_byte(in_if.in_byte, in_if.frame_last);
        fired = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_limit(cfg_if.output_limit);
        fired = 1'b1;
      end
      stall_cycles = fired ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // present one compressed byte and hold it until taken
  task automatic send_byte(logic [BYTE_W-1:0] b, bit is_last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.frame_last <= is_last;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  // stop sending and wait for every predicted word
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  // limit write, only with the block idle; tokens with no output may still be queued
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain_results();
    repeat (100) @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.output_limit <= v;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void put_copy_head(int unsigned span);
    logic [14:0] stored;
    stored = 15'(span - 1);
    frame_bytes.push_back(TOKEN_COPY | {1'b0, stored[14:8]});
    frame_bytes.push_back(stored[7:0]);
  endfunction

  // Random frame: mostly valid tokens, some broken endings, some pure noise
  function automatic void build_frame(int unsigned lim);
    int unsigned prod;
    int unsigned room;
    int unsigned n;
    int unsigned len;
    int unsigned tokens;
    int unsigned roll;
    bit          stop;
    prod   = 0;
    stop   = 1'b0;
    tokens = $urandom_range(1, 6);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      return;
    end
    for (int t = 0; t < tokens && !stop; t++) begin
      room = lim - prod;
      roll = $urandom_range(99);
      if (roll < 8) begin
        // error, then a few bytes that get discarded
        stop = 1'b1;
        case ($urandom_range(2))
          0: begin
            put_copy_head($urandom_range(1, 32768));
            frame_bytes.push_back(8'h00);
          end
          1: begin
            put_copy_head($urandom_range(prod + 1, 32768));
            frame_bytes.push_back(8'($urandom_range(1, 255)));
          end
          default: begin
            if (room < 127) begin
              frame_bytes.push_back(8'($urandom_range(room + 1, 127)));
            end else begin
              put_copy_head($urandom_range(1, 32768));
              frame_bytes.push_back(8'h00);
            end
          end
        endcase
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      end else if (roll < 14) begin
        // frame ends in the middle of a token
        stop = 1'b1;
        case ($urandom_range(2))
          0: begin
            n = (room < 127) ? room : 127;
            if (n >= 1) begin
              frame_bytes.push_back(8'(n));
              repeat ($urandom_range(0, n - 1)) frame_bytes.push_back(8'($urandom));
            end else begin
              frame_bytes.push_back(TOKEN_COPY | 8'($urandom_range(0, 127)));
            end
          end
          1: frame_bytes.push_back(TOKEN_COPY | 8'($urandom_range(0, 127)));
          default: put_copy_head($urandom_range(1, 32768));
        endcase
      end else if (roll < 55 || prod == 0) begin
        // literal run, mostly short
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
        if (n > room) n = room;
        frame_bytes.push_back(8'(n));
        repeat (n) frame_bytes.push_back(8'($urandom));
        prod += n;
      end else begin
        // back reference inside the frame, mostly short
        len = ($urandom_range(7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
        if (len > room) len = room;
        if (len == 0) begin
          frame_bytes.push_back(8'h00);
        end else begin
          put_copy_head($urandom_range(1, prod));
          frame_bytes.push_back(8'(len));
          prod += len;
        end
      end
    end
  endfunction

  task automatic run_phase(int unsigned items, logic [LIMIT_W-1:0] lim_val, bit mid_drain);
    int unsigned sent;
    int unsigned gen_lim;
    bit          drained;
    write_limit(lim_val);
    gen_lim = (lim_val < FRAME_MAX) ? int'(lim_val) : FRAME_MAX;
    sent    = 0;
    drained = 1'b0;
    while (sent < items) begin
      build_frame(gen_lim);
      sent += frame_bytes.size();
      send_frame();
      if (mid_drain && !drained && sent >= items / 2) begin
        drain_results();
        drained = 1'b1;
      end
    end
  endtask

  // stimulus
  initial begin
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.frame_last    = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.output_limit = LIMIT_RESET;
    rst_n               = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // literals with extreme bytes, then an overlapping copy ending the frame
    frame_bytes = '{8'h03, 8'h00, 8'hFF, 8'hA5, 8'h80, 8'h02, 8'h05};
    send_frame();
    // empty literal run alone: done word without data
    frame_bytes = '{8'h00};
    send_frame();
    // zero length with a far offset, rest of frame dropped
    frame_bytes = '{8'h01, 8'h7E, 8'hFF, 8'hFF, 8'h00, 8'h55};
    send_frame();
    // offset past the bytes written, error on the last byte
    frame_bytes = '{8'h01, 8'h11, 8'h80, 8'h01, 8'h01};
    send_frame();
    // literal run cut short
    frame_bytes = '{8'h02, 8'h33};
    send_frame();
    // frame ends after a copy token
    frame_bytes = '{8'h85};
    send_frame();
    // longest copy, offset one
    frame_bytes = '{8'h01, 8'h5A, 8'h80, 8'h00, 8'hFF};
    send_frame();

    // zero limit: any non-empty run overflows, an empty one is fine
    write_limit('0);
    frame_bytes = '{8'h02};
    send_frame();
    frame_bytes = '{8'h00};
    send_frame();

    // random frames under several limits
    run_phase(40, 11'd1, 1'b0);
    no_idle = 1'b1;
    run_phase(50, 11'd2047, 1'b0);
    no_idle = 1'b0;
    run_phase(60, LIMIT_W'($urandom_range(16, 300)), 1'b1);
    run_phase(70, LIMIT_RESET, 1'b0);

    drain_results();
    repeat (200) @(negedge clk);
    sb.finish_check();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
